/* hdl/hoct_pkg.sv */
// ----------------------------------------------------------------------------
// hoct_pkg
// Shared types, constants and widths of the half-open connection tracker.
// ----------------------------------------------------------------------------
package hoct_pkg;

   localparam int unsigned FlowsDefault = 64;
   localparam int unsigned PortsDefault = 16;

   localparam logic [7:0] PROTO_TCP = 8'd6;

   typedef enum logic [2:0] {
      ST_DONE       = 3'd0,
      ST_NOT_TCP    = 3'd1,
      ST_TABLE_FULL = 3'd2,
      ST_SLOTS_FULL = 3'd3,
      ST_NO_FLOW    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FLOW_RD,
      S_FLOW_CMP,
      S_DECIDE,
      S_SLOT_RD,
      S_SLOT_CMP,
      S_FINISH,
      S_CLEAR,
      S_OUT
   } state_type;

   // comparator job handed to the shared compare unit
   typedef struct packed {
      logic        en;
      logic [63:0] a;
      logic [63:0] b;
   } cmp_req_type;

endpackage

/* hdl/hoct_cmp.sv */
// ----------------------------------------------------------------------------
// hoct_cmp
// Shared registered compare unit: one equality test a cycle.
// ----------------------------------------------------------------------------
module hoct_cmp
   import hoct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmp_req_type req,
   output logic        hit
);

   logic hit_ff;
   logic hit_in;

   assign hit_in = req.en && (req.a == req.b);

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign hit = hit_ff;

endmodule

/* hdl/half_open_connection_tracker.sv */
// ----------------------------------------------------------------------------
// half_open_connection_tracker
// Half-open TCP connection table keyed by address pair, with alarm.
// ----------------------------------------------------------------------------
// One request at a time, on a sequencer that drives a single shared compare
// unit. Flow entries (in use, half-open count, address pair) and port slots
// (in use, port pair) live in two memories. Each memory is read one address a
// cycle into a register and written one address a cycle.
// After reset a clearing pass zeroes both memories, one slot entry and its
// flow entry a cycle, and req_ready stays low until it is over.
// The flow walk takes each entry through read, compare and decide. It stops
// at the matching flow or at the last entry. The slot walk then takes each
// slot through read, compare and finish. A SYN stops at the first free slot.
// An ACK walks all PORTS slots. A SYN to a new flow goes to slot 0, which is
// free because a flow is only released when its count is zero.
// The response is held in an output register. req_ready stays low until the
// response is taken, and the next request can be accepted in the cycle after.
// Requests therefore do not overlap: a new one is accepted only once the last
// response has been taken.
module half_open_connection_tracker
   import hoct_pkg::*;
#(
   parameter int unsigned FLOWS = FlowsDefault,
   parameter int unsigned PORTS = PortsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [0:0]  req_cmd,
   input  logic [7:0]  req_protocol,
   input  logic [31:0] req_src_addr,
   input  logic [31:0] req_dst_addr,
   input  logic [15:0] req_src_port,
   input  logic [15:0] req_dst_port,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [4:0]  rsp_open_count,
   output logic        rsp_alarm,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int unsigned FW = (FLOWS > 1) ? $clog2(FLOWS) : 1;
   localparam int unsigned PW = (PORTS > 1) ? $clog2(PORTS) : 1;
   localparam int unsigned CW = $clog2(PORTS + 1);
   localparam int unsigned SW = FW + PW;
   localparam int unsigned FDEPTH = 1 << FW;
   localparam int unsigned SDEPTH = 1 << SW;

   typedef struct packed {
      logic          used;
      logic [CW-1:0] count;
      logic [63:0]   key;
   } flow_entry_type;

   typedef struct packed {
      logic        used;
      logic [31:0] ports;
   } slot_entry_type;

   // state
   state_type state_ff, state_in;
   logic [7:0] thr_ff;
   flow_entry_type flow_mem [FDEPTH];
   slot_entry_type slot_mem [SDEPTH];

   // request hold
   logic        cmd_ff;
   logic [63:0] key_ff;
   logic [31:0] ports_ff;

   // walk
   logic [SW-1:0] wipe_ff, wipe_in;
   logic [FW:0] fi_ff, fi_in;
   logic [PW:0] si_ff, si_in;
   logic [FW-1:0] flow_ff, flow_in;
   logic        freeok_ff, freeok_in;
   logic [FW-1:0] free_ff, free_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   flow_entry_type frd_ff;
   slot_entry_type srd_ff;
   logic        rdv_ff;

   logic [2:0]  st_ff, st_in;
   logic [4:0]  oc_ff, oc_in;
   logic        rv_ff;

   cmp_req_type creq;
   logic        chit;

   hoct_cmp u_cmp (.clock(clock), .reset(reset), .req(creq), .hit(chit));

   logic [FW-1:0] fidx;
   logic [SW-1:0] sidx;
   assign fidx = fi_ff[FW-1:0];
   assign sidx = {flow_ff, si_ff[PW-1:0]};

   // memory reads, registered
   always_ff @(posedge clock) begin
      frd_ff <= flow_mem[fidx];
      srd_ff <= slot_mem[sidx];
   end

   always_comb begin
      creq.en = 1'b0;
      creq.a  = key_ff;
      creq.b  = frd_ff.key;
      if (state_ff == S_FLOW_CMP) begin
         creq.en = rdv_ff;
      end else if (state_ff == S_SLOT_CMP) begin
         creq.en = rdv_ff;
         creq.a  = {32'd0, ports_ff};
         creq.b  = {32'd0, srd_ff.ports};
      end
   end

   logic accept;
   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign accept = req_valid && req_ready;

   // memory write ports
   logic           fwe, swe;
   logic [FW-1:0]  fwa;
   logic [SW-1:0]  swa;
   flow_entry_type fwd;
   slot_entry_type swd;
   logic           fhit;

   always_comb begin
      state_in = state_ff; wipe_in = wipe_ff; fi_in = fi_ff; si_in = si_ff;
      flow_in = flow_ff; freeok_in = freeok_ff; free_in = free_ff;
      cnt_in = cnt_ff; st_in = st_ff; oc_in = oc_ff;
      fwe = 1'b0; fwa = flow_ff; fwd = '0;
      swe = 1'b0; swa = sidx; swd = '0;
      fhit = frd_ff.used && chit;
      unique case (state_ff)
         S_CLEAR: begin
            // post-reset pass: every slot entry, and its flow entry, to zero
            fwe = 1'b1; fwa = wipe_ff[SW-1:PW];
            swe = 1'b1; swa = wipe_ff;
            if (wipe_ff == '1) begin
               state_in = S_IDLE;
            end else begin
               wipe_in = wipe_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               fi_in = '0; freeok_in = 1'b0;
               if (req_protocol != PROTO_TCP) begin
                  st_in = ST_NOT_TCP; oc_in = '0; state_in = S_OUT;
               end else begin
                  state_in = S_FLOW_RD;
               end
            end
         end
         S_FLOW_RD: state_in = S_FLOW_CMP;   // read entry registered
         S_FLOW_CMP: state_in = S_DECIDE;    // compare registered
         S_DECIDE: begin
            if (!frd_ff.used && !freeok_ff) begin
               freeok_in = 1'b1; free_in = fidx;
            end
            if (fi_ff == FW'(FLOWS - 1) || fhit) begin
               state_in = S_SLOT_RD; si_in = '0;
               if (!fhit) begin
                  if (cmd_ff) begin
                     st_in = ST_NO_FLOW; oc_in = '0; state_in = S_OUT;
                  end else if (!freeok_ff && frd_ff.used) begin
                     st_in = ST_TABLE_FULL; oc_in = '0; state_in = S_OUT;
                  end else begin
                     // new flow: lowest free entry, all its slots already empty
                     flow_in = freeok_ff ? free_ff : fidx;
                     cnt_in = '0;
                  end
               end else begin
                  flow_in = fidx;
                  cnt_in = frd_ff.count;
                  if (!cmd_ff && frd_ff.count >= CW'(PORTS)) begin
                     st_in = ST_SLOTS_FULL; oc_in = 5'(frd_ff.count);
                     state_in = S_OUT;
                  end
               end
            end else begin
               fi_in = fi_ff + 1'b1; state_in = S_FLOW_RD;
            end
         end
         S_SLOT_RD: state_in = S_SLOT_CMP;
         S_SLOT_CMP: state_in = S_FINISH;
         S_FINISH: begin
            if (!cmd_ff) begin
               if (!srd_ff.used) begin
                  swe = 1'b1; swd.used = 1'b1; swd.ports = ports_ff;
                  cnt_in = cnt_ff + 1'b1;
                  fwe = 1'b1; fwd.used = 1'b1; fwd.count = cnt_in; fwd.key = key_ff;
                  st_in = ST_DONE; oc_in = 5'(cnt_in); state_in = S_OUT;
               end
            end else if (srd_ff.used && chit) begin
               swe = 1'b1;
               if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
            end
            if (state_in != S_OUT) begin
               if (si_ff == PW'(PORTS - 1)) begin
                  // flow released once its count reaches zero
                  fwe = 1'b1; fwd.used = (cnt_in != '0); fwd.count = cnt_in;
                  fwd.key = key_ff;
                  st_in = ST_DONE; oc_in = 5'(cnt_in);
                  state_in = S_OUT;
               end else begin
                  si_in = si_ff + 1'b1; state_in = S_SLOT_RD;
               end
            end
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; wipe_ff <= '0; thr_ff <= '0;
         rv_ff <= 1'b0; rdv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wipe_ff <= wipe_in;
         rdv_ff <= (state_ff == S_FLOW_RD) || (state_ff == S_SLOT_RD);
         if (csr_we) thr_ff <= csr_wdata;
         if (state_ff == S_OUT) rv_ff <= 1'b1;
         else if (rv_ff && rsp_ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fwe) flow_mem[fwa] <= fwd;
      if (swe) slot_mem[swa] <= swd;
   end

   always_ff @(posedge clock) begin
      fi_ff <= fi_in; si_ff <= si_in; flow_ff <= flow_in;
      freeok_ff <= freeok_in; free_ff <= free_in; cnt_ff <= cnt_in;
      st_ff <= st_in; oc_ff <= oc_in;
      if (accept) begin
         cmd_ff <= req_cmd[0];
         key_ff <= {req_src_addr, req_dst_addr};
         ports_ff <= {req_src_port, req_dst_port};
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_status     = st_ff;
   assign rsp_open_count = oc_ff;
   assign rsp_alarm      = (oc_ff != '0) && ({3'd0, oc_ff} >= thr_ff);

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the half-open connection tracker: requests are
// queued by a stimulus block, driven with random gaps, and every response is
// checked against a behavioural table model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import hoct_pkg::*;

   localparam int NFLOW = 64;
   localparam int NSLOT = 16;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int DRAIN_CYCLES = 2 * NFLOW + 2 * NSLOT + 40;
   localparam int LONG_HOLD = 3000;

   typedef struct packed {
      logic [0:0]  cmd;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } hdr_type;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] open_count;
      logic       alarm;
   } verdict_type;

   localparam logic [0:0] CMD_SYN = 1'b0;
   localparam logic [0:0] CMD_ACK = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hdr_type req_hdr = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status;
   logic [4:0] rsp_open_count;
   logic rsp_alarm;
   logic csr_we = 1'b0;
   logic [7:0] csr_wdata = '0;

   half_open_connection_tracker u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_hdr.cmd),
      .req_protocol   (req_hdr.protocol),
      .req_src_addr   (req_hdr.src_addr),
      .req_dst_addr   (req_hdr.dst_addr),
      .req_src_port   (req_hdr.src_port),
      .req_dst_port   (req_hdr.dst_port),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_open_count (rsp_open_count),
      .rsp_alarm      (rsp_alarm),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---- table model -------------------------------------------------------
   logic [7:0]  mdl_threshold;
   logic        mdl_flow_used [NFLOW];
   logic [31:0] mdl_flow_src [NFLOW];
   logic [31:0] mdl_flow_dst [NFLOW];
   int          mdl_flow_cnt [NFLOW];
   logic        mdl_slot_used [NFLOW][NSLOT];
   logic [31:0] mdl_slot_ports [NFLOW][NSLOT];

   hdr_type     pending_hdrs[$];   // requests waiting for the driver
   verdict_type expected_rsps[$];  // responses owed by the block
   int mismatches = 0;

   function automatic verdict_type make_verdict(status_type st, int cnt);
      verdict_type v;
      v.status = st;
      v.open_count = cnt[4:0];
      v.alarm = (cnt != 0) && (cnt >= int'(mdl_threshold));
      return v;
   endfunction

   // Applies one accepted request to the table model, returns its response.
   function automatic verdict_type track_header(hdr_type h);
      int f;
      logic [31:0] pp;
      f = -1;
      pp = {h.src_port, h.dst_port};
      if (h.protocol != PROTO_TCP) return make_verdict(ST_NOT_TCP, 0);
      for (int i = 0; i < NFLOW; i++)
         if (f < 0 && mdl_flow_used[i] && mdl_flow_src[i] == h.src_addr &&
             mdl_flow_dst[i] == h.dst_addr) f = i;
      if (h.cmd == CMD_SYN) begin
         if (f < 0) begin
            for (int i = 0; i < NFLOW; i++)
               if (f < 0 && !mdl_flow_used[i]) f = i;
            if (f < 0) return make_verdict(ST_TABLE_FULL, 0);
            mdl_flow_used[f] = 1'b1;
            mdl_flow_src[f] = h.src_addr;
            mdl_flow_dst[f] = h.dst_addr;
            mdl_flow_cnt[f] = 0;
            for (int k = 0; k < NSLOT; k++) mdl_slot_used[f][k] = 1'b0;
         end
         if (mdl_flow_cnt[f] >= NSLOT) return make_verdict(ST_SLOTS_FULL, mdl_flow_cnt[f]);
         for (int k = 0; k < NSLOT; k++) begin
            if (!mdl_slot_used[f][k]) begin
               mdl_slot_used[f][k] = 1'b1;
               mdl_slot_ports[f][k] = pp;
               mdl_flow_cnt[f]++;
               break;
            end
         end
         return make_verdict(ST_DONE, mdl_flow_cnt[f]);
      end
      if (f < 0) return make_verdict(ST_NO_FLOW, 0);
      for (int k = 0; k < NSLOT; k++) begin
         if (mdl_slot_used[f][k] && mdl_slot_ports[f][k] == pp) begin
            mdl_slot_used[f][k] = 1'b0;
            if (mdl_flow_cnt[f] > 0) mdl_flow_cnt[f]--;
         end
      end
      if (mdl_flow_cnt[f] == 0) mdl_flow_used[f] = 1'b0;
      return make_verdict(ST_DONE, mdl_flow_cnt[f]);
   endfunction

   // ---- stimulus helpers --------------------------------------------------
   // small address/port pools so that SYN and ACK hit the same flows
   function automatic hdr_type pool_header(logic [0:0] c, int naddr, int nport);
      hdr_type h;
      h.cmd = c;
      h.protocol = PROTO_TCP;
      h.src_addr = 32'h0a00_0000 + $urandom_range(0, naddr - 1);
      h.dst_addr = 32'hc0a8_0000 + $urandom_range(0, 1);
      h.src_port = 16'(32'd1000 + $urandom_range(0, nport - 1));
      h.dst_port = 16'(32'd80 + $urandom_range(0, 1));
      return h;
   endfunction

   function automatic hdr_type wild_header();
      hdr_type h;
      h.cmd = 1'($urandom_range(0, 1));
      h.protocol = ($urandom_range(0, 3) == 0) ? 8'($urandom) : PROTO_TCP;
      h.src_addr = $urandom;
      h.dst_addr = $urandom;
      h.src_port = 16'($urandom);
      h.dst_port = 16'($urandom);
      return h;
   endfunction

   // ---- driver ------------------------------------------------------------
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         // previous request (if any) was accepted at this edge
         if (req_valid) expected_rsps.push_back(track_header(req_hdr));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_hdrs.size() > 0) begin
            req_hdr <= pending_hdrs.pop_front();
            req_valid <= 1'b1;
            send_gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                        : ($urandom_range(0, 1) ? 0 : $urandom_range(0, 3));
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---- receiver back-pressure --------------------------------------------
   // long_hold asks once for a long hold; its length is counted here
   int stall_left = 0;
   logic long_hold = 1'b0;
   logic hold_taken = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold && !hold_taken) begin
         hold_taken <= 1'b1;
         stall_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0)
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                          : $urandom_range(1, 4);
      end
   end

   // ---- monitor -----------------------------------------------------------
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d count=%0d alarm=%0d",
                        rsp_status, rsp_open_count, rsp_alarm);
         end else begin
            want = expected_rsps.pop_front();
            if (want.status !== rsp_status || want.open_count !== rsp_open_count ||
                want.alarm !== rsp_alarm) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d cnt=%0d al=%0d, got st=%0d cnt=%0d al=%0d",
                           want.status, want.open_count, want.alarm,
                           rsp_status, rsp_open_count, rsp_alarm);
            end
         end
      end
   end

   // ---- watchdog ----------------------------------------------------------
   int cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("half_open_connection_tracker test failed");
         $finish;
      end
   end

   // ---- phases ------------------------------------------------------------
   task automatic wait_drained();
      while (pending_hdrs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [7:0] v);
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(posedge clock);
      mdl_threshold = v;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      hdr_type h;
      mdl_threshold = '0;
      for (int i = 0; i < NFLOW; i++) begin
         mdl_flow_used[i] = 1'b0;
         mdl_flow_cnt[i] = 0;
         for (int k = 0; k < NSLOT; k++) mdl_slot_used[i][k] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset threshold 0, then 1 for the first alarms
      write_threshold(8'd1);
      h = '{cmd: CMD_ACK, protocol: PROTO_TCP, src_addr: 32'h1, dst_addr: 32'h2,
            src_port: 16'h0, dst_port: 16'h0};
      pending_hdrs.push_back(h);                  // ACK, no flow
      h.protocol = 8'hff; pending_hdrs.push_back(h); // not TCP
      h.protocol = 8'h00; h.cmd = CMD_SYN; pending_hdrs.push_back(h);
      // extreme addresses/ports, then 17 SYNs into one flow to fill slots
      h = '{cmd: CMD_SYN, protocol: PROTO_TCP, src_addr: 32'hffff_ffff,
            dst_addr: 32'hffff_ffff, src_port: 16'hffff, dst_port: 16'hffff};
      for (int i = 0; i < NSLOT + 1; i++) pending_hdrs.push_back(h);  // duplicates too
      h.cmd = CMD_ACK; h.dst_port = 16'h0;
      pending_hdrs.push_back(h);                  // ACK, no matching slot
      h.dst_port = 16'hffff;
      pending_hdrs.push_back(h);                  // clears all, frees the flow
      h.src_addr = 32'h0; h.dst_addr = 32'h0; h.src_port = 16'h0; h.dst_port = 16'h0;
      h.cmd = CMD_SYN; pending_hdrs.push_back(h);
      h.cmd = CMD_ACK; pending_hdrs.push_back(h);
      wait_drained();

      // fill the flow table, overflow it, then free everything
      write_threshold(8'd255);
      for (int i = 0; i < NFLOW + 2; i++) begin
         h = '{cmd: CMD_SYN, protocol: PROTO_TCP, src_addr: 32'h5000_0000 + i,
               dst_addr: 32'h6000_0000, src_port: 16'h1234, dst_port: 16'h5678};
         pending_hdrs.push_back(h);
      end
      // long receiver hold while the sender keeps offering
      long_hold <= 1'b1;
      for (int i = 0; i < NFLOW + 2; i++) begin
         h = '{cmd: CMD_ACK, protocol: PROTO_TCP, src_addr: 32'h5000_0000 + i,
               dst_addr: 32'h6000_0000, src_port: 16'h1234, dst_port: 16'h5678};
         pending_hdrs.push_back(h);
      end
      wait_drained();

      // random phases over several thresholds
      for (int ph = 0; ph < 5; ph++) begin
         write_threshold(ph == 0 ? 8'd0 : ph == 4 ? 8'd255 : 8'($urandom_range(1, 17)));
         for (int n = 0; n < 320; n++) begin
            if ($urandom_range(0, 9) < 8)
               h = pool_header($urandom_range(0, 2) ? CMD_SYN : CMD_ACK,
                               (ph == 2) ? 40 : 6, 5);
            else
               h = wild_header();
            pending_hdrs.push_back(h);
         end
         wait_drained();
      end

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("half_open_connection_tracker test passed");
      else
         $display("half_open_connection_tracker test failed");
      $finish;
   end

endmodule
